/* rtl/lkvc_pkg.sv */
// lkvc_pkg: shared types and constants for the lru key/value cache
// depends on nothing; used by lkvc_pick, lkvc_store and lru_key_value_cache
`timescale 1ns / 1ps

package lkvc_pkg;

    // capacity register
    localparam int          CAP_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // parameter defaults
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_W_DEF     = 32;
    localparam int VALUE_W_DEF   = 32;

    // request codes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    // state update plan handed from the pick logic to the store
    typedef struct packed {
        logic promote;   // make the selected slot most recent, age younger entries
        logic alloc;     // fill the selected free slot, age every valid entry
        logic wr_pair;   // write key and value into the selected slot
    } t_upd;

endpackage

/* rtl/lkvc_pick.sv */
// lkvc_pick: parallel key match, victim and free-slot selection, result forming
// depends on lkvc_pkg; fed by the state held in lkvc_store
`timescale 1ns / 1ps

module lkvc_pick #(
    parameter int DEPTH       = lkvc_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH   = lkvc_pkg::KEY_W_DEF,
    parameter int VALUE_WIDTH = lkvc_pkg::VALUE_W_DEF,
    localparam int AW         = $clog2(DEPTH),
    localparam int CW         = $clog2(DEPTH + 1)
) (
    input  lkvc_pkg::t_op                       i_op,
    input  logic [KEY_WIDTH-1:0]                i_key,
    input  logic [CW-1:0]                       i_cap,
    input  logic [DEPTH-1:0]                    i_valid,
    input  logic [DEPTH-1:0][KEY_WIDTH-1:0]     i_keys,
    input  logic [DEPTH-1:0][VALUE_WIDTH-1:0]   i_values,
    input  logic [DEPTH-1:0][AW-1:0]            i_ages,
    input  logic [CW-1:0]                       i_count,
    output lkvc_pkg::t_upd                      o_upd,
    output logic [DEPTH-1:0]                    o_slot,
    output logic [AW-1:0]                       o_old_rank,
    output logic                                o_hit,
    output logic [VALUE_WIDTH-1:0]              o_read_value,
    output logic                                o_evicted,
    output logic [KEY_WIDTH-1:0]                o_evicted_key
);

    logic [DEPTH-1:0]       match;
    logic [DEPTH-1:0]       victim;
    logic [DEPTH-1:0]       free_slot;
    logic [DEPTH-1:0]       empty;
    logic [AW-1:0]          oldest_rank;
    logic [VALUE_WIDTH-1:0] match_value;
    logic [AW-1:0]          match_age;
    logic [KEY_WIDTH-1:0]   victim_key;
    logic                   found;
    logic                   full;

    // oldest valid entry holds rank count-1
    assign oldest_rank = AW'(i_count - CW'(1));

    // per-entry compares
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match[i]  = i_valid[i] && (i_keys[i] == i_key);
            victim[i] = i_valid[i] && (i_ages[i] == oldest_rank);
        end
    end

    // lowest empty slot: isolate the lowest set bit
    assign empty     = ~i_valid;
    assign free_slot = empty & (~empty + DEPTH'(1));

    // or-reduce fields of the selected entries (at most one bit set)
    always_comb begin
        match_value = '0;
        match_age   = '0;
        victim_key  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            match_value = match_value | (i_values[i] & {VALUE_WIDTH{match[i]}});
            match_age   = match_age   | (i_ages[i]   & {AW{match[i]}});
            victim_key  = victim_key  | (i_keys[i]   & {KEY_WIDTH{victim[i]}});
        end
    end

    assign found = |match;
    assign full  = (i_count >= i_cap);

    // decide result and update
    always_comb begin
        o_upd         = '0;
        o_slot        = match;
        o_old_rank    = match_age;
        o_hit         = found;
        o_read_value  = '0;
        o_evicted     = 1'b0;
        o_evicted_key = '0;
        unique case (i_op)
            lkvc_pkg::OP_LOOKUP: begin
                o_upd.promote = found;
                o_read_value  = match_value;
            end
            lkvc_pkg::OP_INSERT: begin
                o_upd.wr_pair = 1'b1;
                if (found) begin
                    o_upd.promote = 1'b1;
                end else if (full) begin
                    o_upd.promote = 1'b1;
                    o_slot        = victim;
                    o_old_rank    = oldest_rank;
                    o_evicted     = 1'b1;
                    o_evicted_key = victim_key;
                end else begin
                    o_upd.alloc = 1'b1;
                    o_slot      = free_slot;
                end
            end
            default: begin
                o_upd = '0;
            end
        endcase
    end

endmodule

/* rtl/lkvc_store.sv */
// lkvc_store: entry registers (valid, key, value, recency rank) and entry count
// depends on lkvc_pkg; applies the update plan from lkvc_pick
`timescale 1ns / 1ps

module lkvc_store #(
    parameter int DEPTH       = lkvc_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH   = lkvc_pkg::KEY_W_DEF,
    parameter int VALUE_WIDTH = lkvc_pkg::VALUE_W_DEF,
    localparam int AW         = $clog2(DEPTH),
    localparam int CW         = $clog2(DEPTH + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  lkvc_pkg::t_upd                      i_upd,
    input  logic [DEPTH-1:0]                    i_slot,
    input  logic [AW-1:0]                       i_old_rank,
    input  logic [KEY_WIDTH-1:0]                i_key,
    input  logic [VALUE_WIDTH-1:0]              i_value,
    output logic [DEPTH-1:0]                    o_valid,
    output logic [DEPTH-1:0][KEY_WIDTH-1:0]     o_keys,
    output logic [DEPTH-1:0][VALUE_WIDTH-1:0]   o_values,
    output logic [DEPTH-1:0][AW-1:0]            o_ages,
    output logic [CW-1:0]                       o_count
);

    logic [DEPTH-1:0]                   r_valid, n_valid;
    logic [DEPTH-1:0][AW-1:0]           r_age,   n_age;
    logic [CW-1:0]                      r_count, n_count;
    logic [DEPTH-1:0][KEY_WIDTH-1:0]    r_key;
    logic [DEPTH-1:0][VALUE_WIDTH-1:0]  r_value;

    // next valid bits, ranks and count
    always_comb begin
        n_valid = r_valid;
        n_age   = r_age;
        n_count = r_count;
        if (i_en) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i_upd.promote) begin
                    if (i_slot[i]) begin
                        n_age[i] = '0;
                    end else if (r_valid[i] && (r_age[i] < i_old_rank)) begin
                        n_age[i] = r_age[i] + AW'(1);
                    end
                end else if (i_upd.alloc) begin
                    if (i_slot[i]) begin
                        n_valid[i] = 1'b1;
                        n_age[i]   = '0;
                    end else if (r_valid[i]) begin
                        n_age[i] = r_age[i] + AW'(1);
                    end
                end
            end
            if (i_upd.alloc) begin
                n_count = r_count + CW'(1);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_age   <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
            r_count <= n_count;
        end
    end

    // key/value payload, no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_en && i_upd.wr_pair && i_slot[i]) begin
                r_key[i]   <= i_key;
                r_value[i] <= i_value;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_keys   = r_key;
    assign o_values = r_value;
    assign o_ages   = r_age;
    assign o_count  = r_count;

endmodule

/* rtl/lru_key_value_cache.sv */
// lru_key_value_cache: fully associative key/value cache with lru replacement
// depends on lkvc_pkg, lkvc_pick and lkvc_store
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------------
//  request   | start, busy            | i_operation, i_key, i_value
//  result    | o_done (one-cycle)     | o_hit, o_read_value, o_evicted, o_evicted_key
//  config    | i_cfg_we               | i_cfg_wdata (capacity)
//
// one request per cycle; busy is always low
// a request beat is captured in the request register; from it the match/select logic updates the
// entries and loads the result register, which drives o_done and the result beat
// the receiver cannot stall; every result stands for exactly one cycle
// synchronous active-low reset empties the cache and sets capacity to 16
`timescale 1ns / 1ps

module lru_key_value_cache #(
    parameter int DEPTH       = lkvc_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH   = lkvc_pkg::KEY_W_DEF,
    parameter int VALUE_WIDTH = lkvc_pkg::VALUE_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_operation,
    input  logic [KEY_WIDTH-1:0]        i_key,
    input  logic [VALUE_WIDTH-1:0]      i_value,
    output logic                        o_done,
    output logic                        o_hit,
    output logic [VALUE_WIDTH-1:0]      o_read_value,
    output logic                        o_evicted,
    output logic [KEY_WIDTH-1:0]        o_evicted_key,
    input  logic                        i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]  i_cfg_wdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

    logic [lkvc_pkg::CAP_W-1:0]       r_cap;
    logic                             r_in_vld;
    lkvc_pkg::t_op                    r_op;
    logic [KEY_WIDTH-1:0]             r_key;
    logic [VALUE_WIDTH-1:0]           r_value;
    logic                             r_done;
    logic                             r_hit;
    logic [VALUE_WIDTH-1:0]           r_read_value;
    logic                             r_evicted;
    logic [KEY_WIDTH-1:0]             r_evicted_key;

    logic [CW-1:0]                    cap_eff;
    lkvc_pkg::t_upd                   upd;
    logic [DEPTH-1:0]                 slot;
    logic [AW-1:0]                    old_rank;
    logic                             hit;
    logic [VALUE_WIDTH-1:0]           read_value;
    logic                             evicted;
    logic [KEY_WIDTH-1:0]             evicted_key;
    logic [DEPTH-1:0]                 st_valid;
    logic [DEPTH-1:0][KEY_WIDTH-1:0]  st_keys;
    logic [DEPTH-1:0][VALUE_WIDTH-1:0] st_values;
    logic [DEPTH-1:0][AW-1:0]         st_ages;
    logic [CW-1:0]                    st_count;

    assign busy = 1'b0;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lkvc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // clamp capacity into 1 .. DEPTH
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CW'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(DEPTH)) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = CW'(r_cap);
        end
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op    <= lkvc_pkg::t_op'(i_operation);
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    lkvc_pick #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_pick (
        .i_op          (r_op),
        .i_key         (r_key),
        .i_cap         (cap_eff),
        .i_valid       (st_valid),
        .i_keys        (st_keys),
        .i_values      (st_values),
        .i_ages        (st_ages),
        .i_count       (st_count),
        .o_upd         (upd),
        .o_slot        (slot),
        .o_old_rank    (old_rank),
        .o_hit         (hit),
        .o_read_value  (read_value),
        .o_evicted     (evicted),
        .o_evicted_key (evicted_key)
    );

    lkvc_store #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (r_in_vld),
        .i_upd      (upd),
        .i_slot     (slot),
        .i_old_rank (old_rank),
        .i_key      (r_key),
        .i_value    (r_value),
        .o_valid    (st_valid),
        .o_keys     (st_keys),
        .o_values   (st_values),
        .o_ages     (st_ages),
        .o_count    (st_count)
    );

    // result register: strobe with reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_hit         <= hit;
            r_read_value  <= read_value;
            r_evicted     <= evicted;
            r_evicted_key <= evicted_key;
        end
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

endmodule
